[rtl/core/ffpa_pkg.sv]
package ffpa_pkg;

    // Field widths of the request, response and configuration beats
    localparam int LEN_W       = 32;
    localparam int ADDR_W      = 32;
    localparam int PROC_W      = 8;
    localparam int PAGE_CFG_W  = 11;
    localparam int MEM_BYTES_W = 23;
    localparam int BLK_ADDR_W  = 22;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Page geometry
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_MASK  = (1 << PAGE_SHIFT) - 1;

    // Width of the page count of the largest request: a byte length of up to 2^MEM_BYTES_W - 1
    localparam int NEED_W = MEM_BYTES_W - PAGE_SHIFT + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE_PAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BYTES      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [PAGE_CFG_W-1:0]  FIRST_USABLE_PAGE_RST = 11'd256;
    localparam logic [PAGE_CFG_W-1:0]  TOTAL_PAGES_RST       = 11'd1024;
    localparam logic [MEM_BYTES_W-1:0] MEMORY_BYTES_RST      = 23'd4194304;

    // Request actions
    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    // Response status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

[rtl/core/ffpa_if.sv]
interface ffpa_req_if;
    import ffpa_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [LEN_W-1:0]  length;
    logic [PROC_W-1:0] process;
    logic              kernel_flag;
    logic [ADDR_W-1:0] address;

    modport source (
        output valid, action, length, process, kernel_flag, address,
        input  ready
    );
    modport sink (
        input  valid, action, length, process, kernel_flag, address,
        output ready
    );
endinterface

interface ffpa_rsp_if;
    import ffpa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  status;
    logic [BLK_ADDR_W-1:0] block_address;

    modport source (
        output valid, status, block_address,
        input  ready
    );
    modport sink (
        input  valid, status, block_address,
        output ready
    );
endinterface

interface ffpa_cfg_if;
    import ffpa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

[rtl/core/ffpa_frame_ram.sv]
module ffpa_frame_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 20
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/first_fit_page_frame_allocator.sv]
// First-fit page frame allocator over a table of NUM_FRAMES 4 KiB frames kept in
// one synchronous RAM (one write port, one read port, registered read). After
// reset the block sweeps every frame to free before req.ready first rises;
// configuration writes are taken during that sweep. One request is in work at
// a time. An allocate scans frames one per cycle from first_usable_page, then
// writes the claimed run one frame per cycle. A free walks the block one frame
// per cycle and reads one frame past its end. A request rejected by its length
// or address checks goes straight to the response. The single RAM read port
// sets this pace. A finished beat waits in the response register, so the next
// request is taken while the response is still unclaimed.
module first_fit_page_frame_allocator #(
    parameter int NUM_FRAMES      = 1024,
    parameter int PROCESS_ID_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    ffpa_cfg_if.sink       cfg,
    ffpa_req_if.sink       req,
    ffpa_rsp_if.source     rsp
);
    import ffpa_pkg::*;

    // Frame index width, and a count width wide enough for page counts,
    // the frame limit itself and the 11-bit configuration values.
    localparam int AW     = $clog2(NUM_FRAMES);
    localparam int CNT_W  = (AW + 1 > NEED_W) ? AW + 1 : NEED_W;
    localparam int ENT_W  = 1 + PROCESS_ID_BITS + AW + 1;

    localparam logic [AW-1:0]    LAST_FRAME  = AW'(NUM_FRAMES - 1);
    localparam logic [CNT_W-1:0] FRAMES_CNT  = CNT_W'(NUM_FRAMES);
    localparam logic [ENT_W-1:0] FREE_ENTRY  = {1'b1, {(ENT_W - 1){1'b0}}};

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_CLAIM  = 6'b001000,
        ST_WALK   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [PAGE_CFG_W-1:0]  first_usable_reg;
    logic [PAGE_CFG_W-1:0]  total_pages_reg;
    logic [MEM_BYTES_W-1:0] memory_bytes_reg;

    // Working registers
    logic [CNT_W-1:0]           issue_ptr_reg, issue_ptr_next;
    logic [CNT_W-1:0]           run_reg, run_next;
    logic [CNT_W-1:0]           need_reg, need_next;
    logic [AW-1:0]              page_reg, page_next;
    logic [AW-1:0]              claim_end_reg, claim_end_next;
    logic [AW-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [PROCESS_ID_BITS-1:0] proc_reg, proc_next;
    logic                       kflag_reg, kflag_next;
    logic                       first_reg, first_next;
    logic                       data_valid_reg;
    logic [AW-1:0]              data_page_reg;
    logic                       res_status_reg, res_status_next;
    logic [BLK_ADDR_W-1:0]      res_addr_reg, res_addr_next;

    // Response register
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  rsp_status_reg;
    logic [BLK_ADDR_W-1:0] rsp_addr_reg;
    logic                  rsp_load;

    // Frame RAM port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    // Decoded read entry
    logic          rd_free;
    logic [AW-1:0] rd_start;
    logic          rd_fa;

    // Request checks
    logic [CNT_W-1:0]             total_ext;
    logic [CNT_W-1:0]             lim;
    logic [MEM_BYTES_W:0]         need_sum;
    logic [CNT_W-1:0]             need_calc;
    logic                         len_bad;
    logic [CNT_W-1:0]             free_page;
    logic                         free_bad;
    logic [CNT_W-1:0]             run_inc;
    logic                         scan_hit;
    logic                         walk_match;
    logic [CNT_W+PAGE_SHIFT-1:0]  claim_addr_wide;

    ffpa_frame_ram #(
        .DEPTH  (NUM_FRAMES),
        .ADDR_W (AW),
        .DATA_W (ENT_W)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Entry layout: free mark, owner, start page, free-allowed
    assign rd_free  = mem_rdata[ENT_W-1];
    assign rd_start = mem_rdata[AW:1];
    assign rd_fa    = mem_rdata[0];

    // Scan bound: the smaller of total_pages and the table depth
    assign total_ext = CNT_W'(total_pages_reg);
    assign lim       = (total_ext < FRAMES_CNT) ? total_ext : FRAMES_CNT;

    // Allocate checks; the page count is only used once length fits memory_bytes
    assign len_bad   = (req.length == '0) || (req.length > LEN_W'(memory_bytes_reg));
    assign need_sum  = {1'b0, req.length[MEM_BYTES_W-1:0]} + (MEM_BYTES_W + 1)'(PAGE_MASK);
    assign need_calc = CNT_W'(need_sum[MEM_BYTES_W:PAGE_SHIFT]);

    // Free checks: aligned, nonzero, inside memory and inside the frame table
    assign free_page = CNT_W'(req.address[MEM_BYTES_W-1:PAGE_SHIFT]);
    assign free_bad  = (req.address[PAGE_SHIFT-1:0] != '0) || (req.address == '0) ||
                       (req.address > ADDR_W'(memory_bytes_reg)) || (free_page >= lim);

    // A returning free frame that completes the run ends the scan
    assign run_inc  = run_reg + CNT_W'(1);
    assign scan_hit = data_valid_reg && rd_free && (run_inc == need_reg);

    assign walk_match = (rd_start == page_reg);

    assign claim_addr_wide = {CNT_W'(page_reg), {PAGE_SHIFT{1'b0}}};

    assign rsp_load = (state_reg == ST_FINISH) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        issue_ptr_next  = issue_ptr_reg;
        run_next        = run_reg;
        need_next       = need_reg;
        page_next       = page_reg;
        claim_end_next  = claim_end_reg;
        wr_ptr_next     = wr_ptr_reg;
        proc_next       = proc_reg;
        kflag_next      = kflag_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg;
        mem_wdata       = FREE_ENTRY;
        mem_re          = 1'b0;
        mem_raddr       = issue_ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the table to all free, one frame a cycle
                mem_we      = 1'b1;
                wr_ptr_next = wr_ptr_reg + AW'(1);
                if (wr_ptr_reg == LAST_FRAME)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_addr_next = '0;
                    if (req.action == ACTION_ALLOC)
                    begin
                        if (len_bad)
                        begin
                            res_status_next = STATUS_ERR;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            need_next      = need_calc;
                            run_next       = '0;
                            issue_ptr_next = CNT_W'(first_usable_reg);
                            proc_next      = PROCESS_ID_BITS'(req.process);
                            kflag_next     = req.kernel_flag;
                            state_next     = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_bad)
                        begin
                            res_status_next = STATUS_ERR;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            page_next      = free_page[AW-1:0];
                            issue_ptr_next = free_page;
                            first_next     = 1'b1;
                            state_next     = ST_WALK;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Count the run on the frame read last cycle; reset it on an owned frame
                if (data_valid_reg)
                begin
                    run_next = rd_free ? run_inc : '0;
                end
                if (scan_hit)
                begin
                    page_next      = data_page_reg - run_reg[AW-1:0];
                    wr_ptr_next    = data_page_reg - run_reg[AW-1:0];
                    claim_end_next = data_page_reg;
                    state_next     = ST_CLAIM;
                end
                else if (issue_ptr_reg >= lim)
                begin
                    res_status_next = STATUS_ERR;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    mem_re         = 1'b1;
                    issue_ptr_next = issue_ptr_reg + CNT_W'(1);
                end
            end

            ST_CLAIM:
            begin
                mem_we      = 1'b1;
                mem_wdata   = {1'b0, proc_reg, page_reg, kflag_reg};
                wr_ptr_next = wr_ptr_reg + AW'(1);
                if (wr_ptr_reg == claim_end_reg)
                begin
                    res_status_next = STATUS_OK;
                    res_addr_next   = claim_addr_wide[BLK_ADDR_W-1:0];
                    state_next      = ST_FINISH;
                end
            end

            ST_WALK:
            begin
                if (data_valid_reg && !walk_match)
                begin
                    // The addressed frame itself must head the block
                    res_status_next = first_reg ? STATUS_ERR : STATUS_OK;
                    state_next      = ST_FINISH;
                end
                else
                begin
                    if (data_valid_reg)
                    begin
                        first_next = 1'b0;
                        if (rd_fa)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = data_page_reg;
                        end
                    end
                    if (issue_ptr_reg >= lim)
                    begin
                        res_status_next = STATUS_OK;
                        state_next      = ST_FINISH;
                    end
                    else
                    begin
                        mem_re         = 1'b1;
                        issue_ptr_next = issue_ptr_reg + CNT_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                // Hold until the response register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            wr_ptr_reg     <= '0;
            data_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_ptr_reg     <= wr_ptr_next;
            data_valid_reg <= mem_re;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Configuration registers; writes are masked to the register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_usable_reg <= FIRST_USABLE_PAGE_RST;
            total_pages_reg  <= TOTAL_PAGES_RST;
            memory_bytes_reg <= MEMORY_BYTES_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_FIRST_USABLE_PAGE: first_usable_reg <= cfg.data[PAGE_CFG_W-1:0];
                CFG_TOTAL_PAGES:       total_pages_reg  <= cfg.data[PAGE_CFG_W-1:0];
                CFG_MEMORY_BYTES:      memory_bytes_reg <= cfg.data[MEM_BYTES_W-1:0];
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        issue_ptr_reg  <= issue_ptr_next;
        run_reg        <= run_next;
        need_reg       <= need_next;
        page_reg       <= page_next;
        claim_end_reg  <= claim_end_next;
        proc_reg       <= proc_next;
        kflag_reg      <= kflag_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        if (mem_re)
        begin
            data_page_reg <= mem_raddr;
        end
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_addr_reg   <= res_addr_reg;
        end
    end

    assign cfg.ready         = 1'b1;
    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.block_address = rsp_addr_reg;

`ifndef SYNTHESIS
    a_no_req_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request taken during table clear");

    a_no_same_entry_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("frame read and written in the same cycle");

    a_claim_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLAIM) |-> (wr_ptr_reg <= claim_end_reg))
        else $error("claim write past end of run");

    a_read_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (issue_ptr_reg < lim))
        else $error("frame read beyond scan bound");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("response raised outside finish");
`endif

endmodule

[test/first_fit_page_frame_allocator_tb.sv]
`timescale 1ns / 100ps

module first_fit_page_frame_allocator_tb;
    import ffpa_pkg::*;

    localparam int NUM_FRAMES = 1024;
    localparam int PROCESS_ID_BITS = PROC_W;
    // Index 3 maps to no register; writes to it must leave every register alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic                  status;
        logic [BLK_ADDR_W-1:0] block_address;
    } reply_t;

    logic clk;
    logic rst_n;

    ffpa_cfg_if cfg_bus ();
    ffpa_req_if req_bus ();
    ffpa_rsp_if rsp_bus ();

    first_fit_page_frame_allocator #(
        .NUM_FRAMES      (NUM_FRAMES),
        .PROCESS_ID_BITS (PROCESS_ID_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the frame table: owner (top bit set means free), block start page
    // and the free-allowed mark, plus the three configuration registers.
    logic [PROCESS_ID_BITS:0] owner_tbl [NUM_FRAMES];
    logic [9:0]               start_tbl [NUM_FRAMES];
    logic                     freeable_tbl [NUM_FRAMES];
    logic [PAGE_CFG_W-1:0]    first_page_r;
    logic [PAGE_CFG_W-1:0]    total_pages_r;
    logic [MEM_BYTES_W-1:0]   mem_bytes_r;

    // Replies owed by the block, oldest first
    reply_t awaited_replies [$];
    // Start pages of blocks handed out, used to build well-formed frees
    int     live_pages [$];

    bit steady_flow;
    int fail_count;
    int sent_count;
    int granted_count;
    int released_count;
    int rejected_count;
    int setting_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #30_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Compute the reply to one accepted request and advance the frame table.
    // granted returns the start page of a new block, or -1.
    function automatic reply_t compute_reply(input logic act, input logic [LEN_W-1:0] len,
                                             input logic [PROC_W-1:0] pid, input logic kflag,
                                             input logic [ADDR_W-1:0] addr,
                                             output int granted);
        int          lim;
        int          cur;
        int          run;
        int          start;
        int          p;
        logic [32:0] need;
        reply_t      r;
        lim = (total_pages_r < NUM_FRAMES) ? int'(total_pages_r) : NUM_FRAMES;
        r.status = STATUS_ERR;
        r.block_address = '0;
        granted = -1;
        run = 0;
        if (act == ACTION_ALLOC)
        begin
            // zero length and lengths past the memory size are rejected outright
            if (len != 0 && len <= mem_bytes_r)
            begin
                need = ({1'b0, len} + 33'(PAGE_MASK)) >> PAGE_SHIFT;
                for (cur = first_page_r; cur < lim && granted < 0; cur++)
                begin
                    if (!owner_tbl[cur][PROCESS_ID_BITS])
                        run = 0;
                    else
                    begin
                        run++;
                        if (run == need)
                        begin
                            // the run ends at cur, so it began run-1 frames back
                            start = cur + 1 - run;
                            for (p = start; p <= cur; p++)
                            begin
                                owner_tbl[p]    = {1'b0, pid};
                                start_tbl[p]    = 10'(start);
                                freeable_tbl[p] = kflag;
                            end
                            granted = start;
                            r.status = STATUS_OK;
                            r.block_address = BLK_ADDR_W'(start << PAGE_SHIFT);
                        end
                    end
                end
            end
        end
        else
        begin
            // aligned, nonzero, within memory and within the table
            if (addr[PAGE_SHIFT-1:0] == 0 && addr != 0 && addr <= mem_bytes_r &&
                (addr >> PAGE_SHIFT) < lim)
            begin
                p = int'(addr >> PAGE_SHIFT);
                if (start_tbl[p] == p)
                begin
                    start = p;
                    // frames without the free-allowed mark stay owned
                    while (p < lim && start_tbl[p] == start)
                    begin
                        if (freeable_tbl[p])
                        begin
                            owner_tbl[p]    = {1'b1, {PROCESS_ID_BITS{1'b0}}};
                            start_tbl[p]    = '0;
                            freeable_tbl[p] = 1'b0;
                        end
                        p++;
                    end
                    r.status = STATUS_OK;
                end
            end
        end
        return r;
    endfunction

    // Present one request beat, hold it until taken, then predict its reply
    task automatic send_request(input logic act, input logic [LEN_W-1:0] len,
                                input logic [PROC_W-1:0] pid, input logic kflag,
                                input logic [ADDR_W-1:0] addr);
        int     gap;
        int     granted;
        reply_t rep;
        gap = 0;
        if (!steady_flow)
            while ($urandom_range(0, 99) < 27)
                gap++;
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.action      <= act;
        req_bus.length      <= len;
        req_bus.process     <= pid;
        req_bus.kernel_flag <= kflag;
        req_bus.address     <= addr;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        rep = compute_reply(act, len, pid, kflag, addr, granted);
        awaited_replies.push_back(rep);
        if (granted >= 0)
            live_pages.push_back(granted);
        sent_count++;
        if (rep.status == STATUS_ERR)
            rejected_count++;
        else if (act == ACTION_ALLOC)
            granted_count++;
        else
            released_count++;
    endtask

    // Unused fields carry random bits so that the block must ignore them
    task automatic request_pages(input logic [LEN_W-1:0] len, input logic [PROC_W-1:0] pid,
                                 input logic kflag);
        send_request(ACTION_ALLOC, len, pid, kflag, $urandom);
    endtask

    task automatic return_block(input logic [ADDR_W-1:0] addr);
        send_request(ACTION_FREE, $urandom, PROC_W'($urandom), 1'($urandom), addr);
    endtask

    // Drop valid, wait for every owed reply, then let the block go quiet
    task automatic settle(input int tail);
        int n;
        req_bus.valid <= 1'b0;
        n = 0;
        while (awaited_replies.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (awaited_replies.size() != 0)
        begin
            $error("%0d replies never arrived", awaited_replies.size());
            fail_count++;
            awaited_replies.delete();
        end
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_FIRST_USABLE_PAGE: first_page_r  = data[PAGE_CFG_W-1:0];
            CFG_TOTAL_PAGES:       total_pages_r = data[PAGE_CFG_W-1:0];
            CFG_MEMORY_BYTES:      mem_bytes_r   = data[MEM_BYTES_W-1:0];
            default: ;
        endcase
    endtask

    // Write all three registers back to back, optionally poke the unused index last
    task automatic program_regs(input logic [CFG_DATA_W-1:0] fup, input logic [CFG_DATA_W-1:0] tp,
                                input logic [CFG_DATA_W-1:0] mb, input bit poke_unused);
        write_reg(CFG_FIRST_USABLE_PAGE, fup);
        write_reg(CFG_TOTAL_PAGES, tp);
        write_reg(CFG_MEMORY_BYTES, mb);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, $urandom);
        cfg_bus.valid <= 1'b0;
        setting_count++;
    endtask

    // Length and address checks, exhaustion, run start and the free walk under
    // the reset configuration
    task automatic test_request_checks();
        request_pages(32'd0, 8'd1, 1'b1);                 // zero length
        request_pages(32'hFFFF_FFFF, 8'd1, 1'b1);         // far past memory
        request_pages(32'd4194305, 8'd1, 1'b1);           // one byte past memory
        request_pages(32'd4194304, 8'd1, 1'b1);           // fits memory, not the usable range
        request_pages(32'd3145728, 8'hFF, 1'b1);          // claims every usable frame
        request_pages(32'd1, 8'd2, 1'b1);                 // table full
        return_block(32'd256 << PAGE_SHIFT);
        request_pages(32'd1, 8'd0, 1'b0);                 // 256, not freeable
        request_pages(32'd4096, 8'hA5, 1'b1);             // 257, exact page
        request_pages(32'd4097, 8'h5A, 1'b1);             // 258..259, rounds up
        return_block((32'd257 << PAGE_SHIFT) | 32'h800);  // misaligned
        return_block(32'd0);                              // address zero
        return_block(32'hFFFF_F000);                      // past memory
        return_block(32'h0040_0000);                      // at memory size, past the table
        return_block(32'd259 << PAGE_SHIFT);              // inside a block, not its start
        return_block(32'd256 << PAGE_SHIFT);              // accepted, frame stays owned
        request_pages(32'd4096, 8'd3, 1'b1);              // lands at 260
        return_block(32'd258 << PAGE_SHIFT);
        request_pages(32'd8192, 8'd4, 1'b1);              // refills the hole at 258
        return_block(32'd300 << PAGE_SHIFT);              // never allocated
    endtask

    // Register extremes, masking of wide writes and the unused index
    task automatic test_register_extremes();
        settle(16);
        program_regs(32'd0, 32'd1024, 32'd4194304, 1'b0);
        request_pages(32'd4096, 8'd1, 1'b1);              // page zero is usable now
        return_block(32'd0);                              // but never freeable by address
        settle(16);
        program_regs(32'd1024, 32'd1024, 32'd4194304, 1'b0);
        request_pages(32'd1, 8'd1, 1'b1);                 // scan starts at the bound
        settle(16);
        program_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1);  // masks to 2047, no frames, no memory
        request_pages(32'd1, 8'd1, 1'b1);
        return_block(32'd4096);
        settle(16);
        program_regs(32'd1000, 32'hFFFF_F7FF, 32'hFFFF_FFFF, 1'b1);
        request_pages(32'h7F_FFFF, 8'd9, 1'b1);           // more pages than the table
        request_pages(32'd24 << PAGE_SHIFT, 8'd9, 1'b1);  // exactly the top 24 frames
        request_pages(32'd1, 8'd9, 1'b1);
        return_block(32'd1000 << PAGE_SHIFT);
        settle(16);
        program_regs(32'd256, 32'd1024, 32'd4194304, 1'b1);
        request_pages(32'd1, 8'd7, 1'b0);
    endtask

    // Mostly allocations and frees of live blocks, the rest malformed frees
    task automatic test_random_traffic(input int n_items, input logic [CFG_DATA_W-1:0] fup,
                                       input logic [CFG_DATA_W-1:0] tp,
                                       input logic [CFG_DATA_W-1:0] mb, input bit steady);
        int               i;
        int               r;
        int               k;
        logic [LEN_W-1:0] len;
        logic [ADDR_W-1:0] addr;
        settle(16);
        program_regs(fup, tp, mb, 1'b0);
        steady_flow = steady;
        for (i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50 || live_pages.size() == 0)
            begin
                k = $urandom_range(0, 99);
                if (k < 6)
                    len = 0;
                else if (k < 12)
                    len = $urandom;
                else if (k < 14)
                    len = mem_bytes_r;
                else if (k < 16)
                    len = mem_bytes_r + 1;
                else if (k < 30)
                    len = $urandom_range(1, 4) << PAGE_SHIFT;
                else if (k < 34)
                    len = $urandom_range(1, 262144);
                else
                    len = $urandom_range(1, 16384);
                request_pages(len, PROC_W'($urandom_range(0, 255)),
                              $urandom_range(0, 99) < 80);
            end
            else if (r < 85)
            begin
                k = $urandom_range(0, live_pages.size() - 1);
                addr = live_pages[k] << PAGE_SHIFT;
                // keep a few around so that repeated frees happen
                if ($urandom_range(0, 99) < 85)
                    live_pages.delete(k);
                return_block(addr);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: addr = $urandom;
                    1: addr = $urandom_range(0, 1100) << PAGE_SHIFT;
                    2: addr = (live_pages[0] + 1) << PAGE_SHIFT;
                    default: addr = (live_pages[$] << PAGE_SHIFT) + $urandom_range(1, PAGE_MASK);
                endcase
                return_block(addr);
            end
        end
        steady_flow = 1'b0;
    endtask

    // Receiver side: stall about a quarter of the cycles unless held steady
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 27);
        end
    end

    // Check every reply beat against the oldest prediction
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("reply beat with no request awaiting it");
                fail_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_bus.status);
                    fail_count++;
                end
                if (rsp_bus.block_address !== want.block_address)
                begin
                    $error("block_address mismatch: expected 0x%06h, actual 0x%06h",
                           want.block_address, rsp_bus.block_address);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < NUM_FRAMES; i++)
        begin
            owner_tbl[i]    = {1'b1, {PROCESS_ID_BITS{1'b0}}};
            start_tbl[i]    = '0;
            freeable_tbl[i] = 1'b0;
        end
        first_page_r  = FIRST_USABLE_PAGE_RST;
        total_pages_r = TOTAL_PAGES_RST;
        mem_bytes_r   = MEMORY_BYTES_RST;
        steady_flow   = 1'b0;
        fail_count    = 0;
        sent_count    = 0;
        granted_count = 0;
        released_count = 0;
        rejected_count = 0;
        setting_count = 1;

        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.action      = ACTION_ALLOC;
        req_bus.length      = '0;
        req_bus.process     = '0;
        req_bus.kernel_flag = 1'b0;
        req_bus.address     = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_FIRST_USABLE_PAGE;
        cfg_bus.data        = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_request_checks();
        test_register_extremes();
        test_random_traffic(160, 32'd256, 32'd1024, 32'd4194304, 1'b0);
        test_random_traffic(120, 32'd8, 32'd64, 32'd262144, 1'b0);
        test_random_traffic(120, 32'd0, 32'd1024, 32'd4194304, 1'b1);   // no stalls at all
        test_random_traffic(60, 32'd1000, 32'd2047, 32'h7F_FFFF, 1'b0);
        test_random_traffic(120, 32'd100, 32'd300, 32'd1228800, 1'b0);

        settle(64);
        $display("Ran %0d requests over %0d register settings: %0d blocks granted,",
                 sent_count, setting_count, granted_count);
        $display("%0d frees accepted, %0d requests rejected.", released_count, rejected_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/ffpa_pkg.sv
rtl/core/ffpa_if.sv
rtl/core/ffpa_frame_ram.sv
rtl/core/first_fit_page_frame_allocator.sv
test/first_fit_page_frame_allocator_tb.sv
